// ----- src/ppm_rd_pkg.sv -----
// ----------------------------------------------------------------------------
// ppm_rd_pkg
// Shared types and constants for the opcode driven range decoder.
// ----------------------------------------------------------------------------
package ppm_rd_pkg;

	localparam logic [31:0] RANGE_INIT = 32'hffff_ffff;
	localparam logic [2:0]  MAX_FEED   = 3'd4;
	localparam int          DIV_STEPS  = 32;

	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_FEED     = 3'd1,
		OP_COUNT    = 3'd2,
		OP_REMOVE   = 3'd3,
		OP_BIT_DIV  = 3'd4,
		OP_BIT_SHFT = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_ORDER    = 2'd1,
		STAT_COLLAPSE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_R,
		ST_DIV_V,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUB,
		ST_MUL_THR,
		ST_THR,
		ST_NORM,
		ST_DONE
	} state_t;

	localparam logic CFG_CARRYLESS = 1'b0;
	localparam logic CFG_BOTTOM    = 1'b1;

endpackage

// ----- src/ppm_range_decoder.sv -----
// ----------------------------------------------------------------------------
// ppm_range_decoder
// 32-bit range decoder, carryless or code-subtracting by configuration, with low, code and range registers.
// ----------------------------------------------------------------------------
// One input word is taken at a time; in_ready is high only while the sequencer
// is idle. Start, byte feed and rejected words go straight to the done state.
// Count runs two 32-step restoring divisions on one shared divider (range /
// total, then (code - low) / quotient unless that is zero). Divide-form bit
// then runs MUL_LO, MUL_HI and SUB on the shared 32x16 multiplier, then NORM;
// sub-range removal runs the same, shift-form bit MUL_THR, THR and NORM. A
// finished result waits in the output register while the next word is taken.
// bytes_needed reports the compressed bytes to feed before the next operation.
module ppm_range_decoder
	import ppm_rd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [7:0]  byte_in,
	input  logic [15:0] total,
	input  logic [15:0] low_count,
	input  logic [15:0] high_count,
	input  logic [15:0] weight,
	input  logic [4:0]  shift,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] count,
	output logic        bit_res,
	output logic [2:0]  bytes_needed,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [24:0] cfg_data
);

	state_t state_q, state_nx;

	logic        carryless_q;
	logic [24:0] bottom_q;
	logic [31:0] low_q, code_q, range_q;
	logic [2:0]  pend_q, norm_n_q;

	opcode_t     op_q;
	logic [15:0] total_q, lo_q, hi_q, weight_q;
	logic [4:0]  shift_q;
	logic [31:0] mlo_q, mhi_q;

	logic [31:0] res_count_q;
	logic        res_bit_q;
	status_t     res_stat_q;

	logic        out_valid_q;
	logic [31:0] out_count_q;
	logic        out_bit_q;
	logic [2:0]  out_bytes_q;
	status_t     out_stat_q;

	// shared restoring divider
	logic [31:0] div_rem_q, div_quo_q, div_dsr_q;
	logic [4:0]  div_cnt_q;
	logic [32:0] div_trial;
	logic        div_ge, div_last;
	logic [31:0] div_rem_nx, div_quo_nx;

	// shared multiplier
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic [47:0] mul_p;

	// normalization step
	logic [31:0] nsum, bmask, r2, r_eff;
	logic        span, in_acc, out_free;
	logic        dv_bit;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	assign div_trial  = {div_rem_q, div_quo_q[31]} - {1'b0, div_dsr_q};
	assign div_ge     = !div_trial[32];
	assign div_rem_nx = div_ge ? div_trial[31:0] : {div_rem_q[30:0], div_quo_q[31]};
	assign div_quo_nx = {div_quo_q[30:0], div_ge};
	assign div_last   = (div_cnt_q == 5'(DIV_STEPS - 1));

	always_comb begin
		mul_a = (state_q == ST_MUL_THR) ? (range_q >> shift_q) : range_q;
		unique case (state_q)
			ST_MUL_LO: mul_b = lo_q;
			ST_MUL_HI: mul_b = hi_q;
			default:   mul_b = weight_q;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign nsum  = low_q + range_q;
	assign span  = |(low_q[31:24] ^ nsum[31:24]);
	assign bmask = {7'd0, bottom_q} - 32'd1;
	assign r2    = (~low_q + 32'd1) & bmask;
	assign r_eff = span ? r2 : range_q;
	assign dv_bit = (div_quo_nx >= {16'd0, weight_q});

	// next state and handshake
	always_comb begin
		state_nx = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (opcode)
						OP_COUNT, OP_BIT_DIV: begin
							if (pend_q != 3'd0 || total == 16'd0) state_nx = ST_DONE;
							else state_nx = ST_DIV_R;
						end
						OP_REMOVE: state_nx = (pend_q != 3'd0) ? ST_DONE : ST_MUL_LO;
						OP_BIT_SHFT: state_nx = (pend_q != 3'd0) ? ST_DONE : ST_MUL_THR;
						default: state_nx = ST_DONE;
					endcase
				end
			end
			ST_DIV_R: begin
				if (div_last) state_nx = (div_quo_nx == 32'd0) ? ST_DONE : ST_DIV_V;
			end
			ST_DIV_V: begin
				if (div_last) state_nx = (op_q == OP_COUNT) ? ST_DONE : ST_MUL_LO;
			end
			ST_MUL_LO:  state_nx = ST_MUL_HI;
			ST_MUL_HI:  state_nx = ST_SUB;
			ST_SUB:     state_nx = ST_NORM;
			ST_MUL_THR: state_nx = ST_THR;
			ST_THR:     state_nx = ST_NORM;
			ST_NORM: begin
				if (range_q == 32'd0 || span || norm_n_q == MAX_FEED) begin
					if (range_q == 32'd0 || (span && range_q >= {7'd0, bottom_q}) ||
					    (span && r2 == 32'd0) || norm_n_q == MAX_FEED)
						state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carryless_q <= 1'b1;
			bottom_q    <= 25'd32768;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CARRYLESS: carryless_q <= cfg_data[0];
				CFG_BOTTOM:    bottom_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q      <= 32'd0;
			code_q     <= 32'd0;
			range_q    <= RANGE_INIT;
			pend_q     <= 3'd0;
			norm_n_q   <= 3'd0;
			res_stat_q <= STAT_OK;
			res_bit_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						res_stat_q <= STAT_OK;
						res_bit_q  <= 1'b0;
						unique case (opcode)
							OP_START: begin
								low_q   <= 32'd0;
								code_q  <= 32'd0;
								range_q <= RANGE_INIT;
								pend_q  <= MAX_FEED;
							end
							OP_FEED: begin
								if (pend_q == 3'd0) res_stat_q <= STAT_ORDER;
								else begin
									code_q <= {code_q[23:0], byte_in};
									pend_q <= pend_q - 3'd1;
								end
							end
							OP_COUNT, OP_BIT_DIV: begin
								if (pend_q != 3'd0) res_stat_q <= STAT_ORDER;
								else if (total == 16'd0) res_stat_q <= STAT_COLLAPSE;
							end
							OP_REMOVE, OP_BIT_SHFT: begin
								if (pend_q != 3'd0) res_stat_q <= STAT_ORDER;
							end
							default: res_stat_q <= STAT_ORDER;
						endcase
					end
				end
				ST_DIV_R: begin
					if (div_last && div_quo_nx == 32'd0) res_stat_q <= STAT_COLLAPSE;
				end
				ST_DIV_V: begin
					if (div_last) begin
						range_q <= div_dsr_q;
						if (op_q != OP_COUNT) res_bit_q <= dv_bit;
					end
				end
				ST_MUL_HI: begin
					if (carryless_q) low_q <= low_q + mlo_q;
					else code_q <= code_q - mlo_q;
				end
				ST_SUB: begin
					range_q  <= mhi_q - mlo_q;
					norm_n_q <= 3'd0;
				end
				ST_THR: begin
					norm_n_q <= 3'd0;
					if (code_q < mlo_q) begin
						res_bit_q <= 1'b0;
						range_q   <= mlo_q;
					end else begin
						res_bit_q <= 1'b1;
						range_q   <= range_q - mlo_q;
						code_q    <= code_q - mlo_q;
					end
				end
				ST_NORM: begin
					if (range_q == 32'd0) begin
						pend_q     <= norm_n_q;
						res_stat_q <= STAT_COLLAPSE;
					end else if (span && range_q >= {7'd0, bottom_q}) begin
						pend_q <= norm_n_q;
					end else if (span && r2 == 32'd0) begin
						range_q    <= 32'd0;
						pend_q     <= norm_n_q;
						res_stat_q <= STAT_COLLAPSE;
					end else if (norm_n_q == MAX_FEED) begin
						range_q    <= r_eff;
						pend_q     <= norm_n_q;
						res_stat_q <= STAT_COLLAPSE;
					end else begin
						range_q  <= {r_eff[23:0], 8'd0};
						low_q    <= {low_q[23:0], 8'd0};
						norm_n_q <= norm_n_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// operands, divider and multiplier results
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					op_q        <= opcode_t'(opcode);
					total_q     <= total;
					lo_q        <= low_count;
					hi_q        <= high_count;
					weight_q    <= weight;
					shift_q     <= shift;
					res_count_q <= 32'd0;
					div_rem_q   <= 32'd0;
					div_quo_q   <= range_q;
					div_dsr_q   <= {16'd0, total};
					div_cnt_q   <= 5'd0;
				end
			end
			ST_DIV_R: begin
				div_cnt_q <= div_cnt_q + 5'd1;
				if (div_last) begin
					div_rem_q <= 32'd0;
					div_quo_q <= code_q - low_q;
					div_dsr_q <= div_quo_nx;
				end else begin
					div_rem_q <= div_rem_nx;
					div_quo_q <= div_quo_nx;
				end
			end
			ST_DIV_V: begin
				div_cnt_q <= div_cnt_q + 5'd1;
				div_rem_q <= div_rem_nx;
				div_quo_q <= div_quo_nx;
				if (div_last) begin
					if (op_q == OP_COUNT) res_count_q <= div_quo_nx;
					else if (dv_bit) begin
						lo_q <= weight_q;
						hi_q <= total_q;
					end else begin
						lo_q <= 16'd0;
						hi_q <= weight_q;
					end
				end
			end
			ST_MUL_LO:  mlo_q <= mul_p[31:0];
			ST_MUL_HI:  mhi_q <= mul_p[31:0];
			ST_MUL_THR: mlo_q <= mul_p[31:0];
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_count_q <= res_count_q;
			out_bit_q   <= res_bit_q;
			out_bytes_q <= pend_q;
			out_stat_q  <= res_stat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign count        = out_count_q;
	assign bit_res      = out_bit_q;
	assign bytes_needed = out_bytes_q;
	assign status       = out_stat_q;

endmodule

// ----- src/ppm_rd_chk.sv -----
// ----------------------------------------------------------------------------
// ppm_rd_chk
// Port level checks for the range decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ppm_rd_chk
	import ppm_rd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] count,
	input logic        bit_res,
	input logic [2:0]  bytes_needed,
	input logic [1:0]  status
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(count) && $stable(status))
		else $error("result word changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || status == STAT_ORDER || status == STAT_COLLAPSE))
		else $error("undefined status code");

	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bytes_needed <= MAX_FEED)
		else $error("more than four bytes requested");

	// a rejected operation reports no count and no bit
	a_order_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_ORDER |-> count == 32'd0 && !bit_res)
		else $error("rejected operation carries data");

	// a nonzero count only comes from a clean count operation
	a_count_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count != 32'd0 |-> status == STAT_OK && !bit_res)
		else $error("count with error or bit");

endmodule

bind ppm_range_decoder ppm_rd_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.count        (count),
	.bit_res      (bit_res),
	.bytes_needed (bytes_needed),
	.status       (status)
);

// ----- dv/tb_ppm_range_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppm_range_decoder
// Self-checking bench for the opcode driven range decoder. A directed start-up
// sequence is followed by random decode sessions (start, byte feeds, count,
// sub-range removal, weighted bits) mixed with fully random words, across several
// register settings. Every result word is checked against a built-in decoder.
// ----------------------------------------------------------------------------
module tb_ppm_range_decoder;
	import ppm_rd_pkg::*;

	localparam logic [2:0]  OP_RSVD_A     = 3'd6;
	localparam logic [2:0]  OP_RSVD_B     = 3'd7;
	localparam logic [31:0] TOP_SPAN      = 32'h0100_0000;
	localparam int          IDLE_PCT      = 11;
	localparam int          QUIET_START   = 3000;
	localparam int          QUIET_END     = 7000;
	localparam int          STALL_LIMIT   = 3000;
	localparam int          DRAIN_CYCLES  = 100;
	localparam int          PHASE_WORDS   = 52;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  byte_v;
		logic [15:0] tot;
		logic [15:0] lo_c;
		logic [15:0] hi_c;
		logic [15:0] wgt;
		logic [4:0]  shamt;
	} dec_word_t;

	typedef struct packed {
		logic [31:0] count;
		logic        bit_v;
		logic [2:0]  need;
		status_t     stat;
	} dec_result_t;

	typedef struct packed {
		logic        carryless;
		logic [31:0] bottom;
		logic [31:0] low;
		logic [31:0] code;
		logic [31:0] rng;
		logic [2:0]  need;
	} dec_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode = '0;
	logic [7:0]  byte_in = '0;
	logic [15:0] total = '0;
	logic [15:0] low_count = '0;
	logic [15:0] high_count = '0;
	logic [15:0] weight = '0;
	logic [4:0]  shift = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] count;
	logic        bit_res;
	logic [2:0]  bytes_needed;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [24:0] cfg_data = '0;

	dec_word_t   stim_words[$];
	dec_result_t pending_results[$];
	dec_state_t  plan_st;
	dec_state_t  chk_st;
	dec_result_t plan_res;
	dec_word_t   drv_word;
	logic        in_took = 1'b0;
	int          idle_pct = IDLE_PCT;
	int          cyc = 0;
	int          stall_cycles = 0;
	int          mismatches = 0;
	int          planned = 0;

	ppm_range_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.byte_in      (byte_in),
		.total        (total),
		.low_count    (low_count),
		.high_count   (high_count),
		.weight       (weight),
		.shift        (shift),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.count        (count),
		.bit_res      (bit_res),
		.bytes_needed (bytes_needed),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------
	function automatic dec_state_t reset_state();
		dec_state_t s;
		s.carryless = 1'b1;
		s.bottom    = 32'd32768;
		s.low       = '0;
		s.code      = '0;
		s.rng       = RANGE_INIT;
		s.need      = '0;
		return s;
	endfunction

	function automatic void set_reg(inout dec_state_t s, input logic idx,
			input logic [24:0] data);
		if (idx == CFG_CARRYLESS)
			s.carryless = data[0];
		else
			s.bottom = {7'd0, data};
	endfunction

	// Shifts low/range out a byte at a time; returns 1 on collapse.
	function automatic logic renorm(inout dec_state_t s);
		logic [2:0] n;
		n = '0;
		for (int i = 0; i <= 5; i++) begin
			if (s.rng == 0) begin
				s.need = n;
				return 1'b1;
			end
			if ((s.low ^ (s.low + s.rng)) >= TOP_SPAN) begin
				if (s.rng >= s.bottom) begin
					s.need = n;
					return 1'b0;
				end
				s.rng = (32'd0 - s.low) & (s.bottom - 32'd1);
				if (s.rng == 0) begin
					s.need = n;
					return 1'b1;
				end
			end
			if (n == MAX_FEED) begin
				s.need = n;
				return 1'b1;
			end
			n = n + 3'd1;
			s.rng = s.rng << 8;
			s.low = s.low << 8;
		end
		return 1'b1;
	endfunction

	function automatic logic remove_span(inout dec_state_t s, input logic [31:0] lo,
			input logic [31:0] hi);
		if (s.carryless)
			s.low = s.low + s.rng * lo;
		else
			s.code = s.code - s.rng * lo;
		s.rng = s.rng * (hi - lo);
		return renorm(s);
	endfunction

	function automatic dec_result_t decode_step(inout dec_state_t s, input dec_word_t w);
		dec_result_t r;
		logic [31:0] tot32;
		logic [31:0] q;
		logic [31:0] v;
		logic [31:0] thr;
		r = '0;
		tot32 = {16'd0, w.tot};
		if (w.op == OP_START) begin
			s.low  = '0;
			s.code = '0;
			s.rng  = RANGE_INIT;
			s.need = MAX_FEED;
		end else if (w.op == OP_FEED) begin
			if (s.need == 0) begin
				r.stat = STAT_ORDER;
			end else begin
				s.code = {s.code[23:0], w.byte_v};
				s.need = s.need - 3'd1;
			end
		end else if (w.op > OP_BIT_SHFT || s.need != 0) begin
			r.stat = STAT_ORDER;
		end else if (w.op == OP_COUNT || w.op == OP_BIT_DIV) begin
			q = (tot32 != 0) ? s.rng / tot32 : 32'd0;
			if (q == 0) begin
				r.stat = STAT_COLLAPSE;
			end else begin
				v = (s.code - s.low) / q;
				s.rng = q;
				if (w.op == OP_COUNT) begin
					r.count = v;
				end else if (v < {16'd0, w.wgt}) begin
					if (remove_span(s, 32'd0, {16'd0, w.wgt}))
						r.stat = STAT_COLLAPSE;
				end else begin
					r.bit_v = 1'b1;
					if (remove_span(s, {16'd0, w.wgt}, tot32))
						r.stat = STAT_COLLAPSE;
				end
			end
		end else if (w.op == OP_REMOVE) begin
			if (remove_span(s, {16'd0, w.lo_c}, {16'd0, w.hi_c}))
				r.stat = STAT_COLLAPSE;
		end else begin
			thr = (s.rng >> w.shamt) * {16'd0, w.wgt};
			if (s.code < thr) begin
				s.rng = thr;
			end else begin
				r.bit_v = 1'b1;
				s.rng  = s.rng - thr;
				s.code = s.code - thr;
			end
			if (renorm(s))
				r.stat = STAT_COLLAPSE;
		end
		r.need = s.need;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------
	function automatic dec_word_t rand_word();
		dec_word_t w;
		w.op     = 3'($urandom_range(7));
		w.byte_v = 8'($urandom);
		w.tot    = 16'($urandom);
		w.lo_c   = 16'($urandom);
		w.hi_c   = 16'($urandom);
		w.wgt    = 16'($urandom);
		w.shamt  = 5'($urandom);
		return w;
	endfunction

	function automatic dec_word_t word_of(logic [2:0] op, logic [7:0] b, logic [15:0] tot,
			logic [15:0] lo, logic [15:0] hi, logic [15:0] wgt, logic [4:0] sh);
		dec_word_t w;
		w = '{op: op, byte_v: b, tot: tot, lo_c: lo, hi_c: hi, wgt: wgt, shamt: sh};
		return w;
	endfunction

	// Queues a word and tracks the decoder state it leads to.
	task automatic plan_word(input dec_word_t w);
		stim_words.push_back(w);
		plan_res = decode_step(plan_st, w);
		planned++;
	endtask

	task automatic feed_up();
		while (plan_st.need != 0)
			plan_word(word_of(OP_FEED, 8'($urandom), '0, '0, '0, '0, '0));
	endtask

	function automatic logic [15:0] pick_total();
		if ($urandom_range(99) < 55)
			return 16'($urandom_range(2, 300));
		return 16'($urandom_range(2, 65535));
	endfunction

	task automatic plan_session(input int n_ops);
		int unsigned k;
		int unsigned c;
		int unsigned tot;
		int unsigned lo;
		int unsigned hi;
		int unsigned sh;
		int unsigned wmax;
		if ($urandom_range(99) < 75)
			plan_word(word_of(OP_START, 8'($urandom), '0, '0, '0, '0, '0));
		feed_up();
		repeat (n_ops) begin
			k = $urandom_range(99);
			if (k < 30) begin
				tot = {16'd0, pick_total()};
				plan_word(word_of(OP_COUNT, '0, 16'(tot), '0, '0, '0, '0));
				c = plan_res.count;
				if (plan_res.stat == STAT_OK && c < tot) begin
					lo = $urandom_range(0, c);
					hi = $urandom_range(c + 1, tot);
				end else begin
					lo = 0;
					hi = 1;
				end
				plan_word(word_of(OP_REMOVE, '0, '0, 16'(lo), 16'(hi), '0, '0));
			end else if (k < 55) begin
				tot = {16'd0, pick_total()};
				plan_word(word_of(OP_BIT_DIV, '0, 16'(tot), '0, '0,
					16'($urandom_range(1, tot - 1)), '0));
			end else if (k < 85) begin
				sh = $urandom_range(1, 20);
				wmax = (sh >= 16) ? 65535 : (1 << sh) - 1;
				plan_word(word_of(OP_BIT_SHFT, '0, '0, '0, '0,
					16'($urandom_range(1, wmax)), 5'(sh)));
			end else begin
				lo = $urandom_range(0, 65534);
				hi = $urandom_range(lo, 65535);
				plan_word(word_of(OP_REMOVE, '0, '0, 16'(lo), 16'(hi), '0, '0));
			end
			feed_up();
		end
	endtask

	task automatic wait_idle();
		while (stim_words.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [24:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		set_reg(plan_st, idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic mode, input logic [24:0] bottom);
		int goal;
		wait_idle();
		write_reg(CFG_CARRYLESS, {24'd0, mode});
		write_reg(CFG_BOTTOM, bottom);
		goal = planned + PHASE_WORDS;
		while (planned < goal) begin
			if ($urandom_range(99) < 15)
				plan_word(rand_word());
			else
				plan_session($urandom_range(1, 6));
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: presents words at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= idle_pct);
			if (!in_valid || in_took) begin
				if (stim_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
					drv_word   = stim_words.pop_front();
					in_valid   <= 1'b1;
					opcode     <= drv_word.op;
					byte_in    <= drv_word.byte_v;
					total      <= drv_word.tot;
					low_count  <= drv_word.lo_c;
					high_count <= drv_word.hi_c;
					weight     <= drv_word.wgt;
					shift      <= drv_word.shamt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor and checker
	// ------------------------------------------------------------------
	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname,
				want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		dec_result_t want;
		if (arst_n) begin
			cyc++;
			idle_pct = (cyc >= QUIET_START && cyc < QUIET_END) ? 0 : IDLE_PCT;
			in_took = in_valid && in_ready;
			if (in_took)
				pending_results.push_back(decode_step(chk_st, word_of(opcode, byte_in,
					total, low_count, high_count, weight, shift)));
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual count %0h status %0h",
						$time, count, status);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("count", want.count, count);
					check_field("bit_res", {31'd0, want.bit_v}, {31'd0, bit_res});
					check_field("bytes_needed", {29'd0, want.need}, {29'd0, bytes_needed});
					check_field("status", {30'd0, want.stat}, {30'd0, status});
				end
			end
			if (cfg_valid && cfg_ready)
				set_reg(chk_st, cfg_index, cfg_data);
			if (in_took || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	initial begin
		wait (arst_n);
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		plan_st = reset_state();
		chk_st  = reset_state();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// out of reset: nothing pending, range at full scale
		plan_word(word_of(OP_FEED, 8'h00, '0, '0, '0, '0, '0));
		plan_word(word_of(OP_COUNT, '0, 16'hffff, '0, '0, '0, '0));
		plan_word(word_of(OP_RSVD_A, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 5'h1f));
		plan_word(word_of(OP_RSVD_B, '0, '0, '0, '0, '0, '0));
		plan_word(word_of(OP_START, '0, '0, '0, '0, '0, '0));
		plan_word(word_of(OP_COUNT, '0, 16'd100, '0, '0, '0, '0));
		plan_word(word_of(OP_FEED, 8'hff, '0, '0, '0, '0, '0));
		plan_word(word_of(OP_FEED, 8'h00, '0, '0, '0, '0, '0));
		plan_word(word_of(OP_FEED, 8'ha5, '0, '0, '0, '0, '0));
		plan_word(word_of(OP_FEED, 8'h5a, '0, '0, '0, '0, '0));
		// zero total is reported as a collapse
		plan_word(word_of(OP_COUNT, '0, 16'd0, '0, '0, '0, '0));
		plan_word(word_of(OP_COUNT, '0, 16'hffff, '0, '0, '0, '0));
		plan_word(word_of(OP_REMOVE, '0, '0, 16'd0, 16'hffff, '0, '0));
		feed_up();
		plan_word(word_of(OP_BIT_DIV, '0, 16'd1, '0, '0, 16'd0, '0));
		feed_up();
		plan_word(word_of(OP_BIT_DIV, '0, 16'hffff, '0, '0, 16'hffff, '0));
		feed_up();
		plan_word(word_of(OP_BIT_SHFT, '0, '0, '0, '0, 16'hffff, 5'd31));
		feed_up();
		plan_word(word_of(OP_BIT_SHFT, '0, '0, '0, '0, 16'd0, 5'd0));
		feed_up();
		// empty sub-range collapses the range, then a bit on a dead range
		plan_word(word_of(OP_REMOVE, '0, '0, 16'hffff, 16'hffff, '0, '0));
		feed_up();
		plan_word(word_of(OP_BIT_SHFT, '0, '0, '0, '0, 16'd1, 5'd0));
		feed_up();
		plan_word(word_of(OP_START, '0, '0, '0, '0, '0, '0));
		feed_up();

		run_phase(1'b0, 25'd32768);
		run_phase(1'b1, 25'd1);
		run_phase(1'b0, 25'h100_0000);
		run_phase(1'b1, 25'd65536);
		run_phase(1'b0, 25'd0);
		run_phase(1'b1, 25'd12345);
		run_phase(1'b1, 25'd32768);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
